### hdl/rsht_pkg.sv
// Recent slot hash table package: sizes, controller states and the
// command/status structs shared by the controller, datapath and top level.
// No dependencies.
package rsht_pkg;

    localparam int CAPACITY = 512;
    localparam int ROW_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = 64;
    localparam int WORD_W   = 64;
    localparam int HASH_W   = 4 * WORD_W;
    localparam int POS_W    = 9;
    localparam int COUNT_W  = 10;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } rsht_state_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic scan;
        logic commit;
    } rsht_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic count_zero;
        logic found;
        logic exhausted;
        logic out_free;
    } rsht_status_t;

endpackage

### hdl/rsht_if.sv
// Request and result channel interfaces of the recent slot hash table.
// Depends on rsht_pkg for field widths.
interface rsht_req_if
    import rsht_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] hash_word0;
    logic [WORD_W-1:0] hash_word1;
    logic [WORD_W-1:0] hash_word2;
    logic [WORD_W-1:0] hash_word3;

    modport source (
        output valid, slot, hash_word0, hash_word1, hash_word2, hash_word3,
        input  ready
    );
    modport sink (
        input  valid, slot, hash_word0, hash_word1, hash_word2, hash_word3,
        output ready
    );
endinterface

interface rsht_rsp_if
    import rsht_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               matched;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic               evicted;

    modport source (
        output valid, matched, position, entry_count, evicted,
        input  ready
    );
    modport sink (
        input  valid, matched, position, entry_count, evicted,
        output ready
    );
endinterface

### hdl/rsht_ctrl.sv
// Controller of the recent slot hash table: sequences accept, scan and commit.
// Depends on rsht_pkg.
module rsht_ctrl
    import rsht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rsht_status_t status,
    output rsht_cmd_t    cmd
);

    rsht_state_t state_reg;
    rsht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.req_valid)
                begin
                    state_next = status.count_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.found || status.exhausted)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.load  = status.req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/rsht_datapath.sv
// Datapath of the recent slot hash table: entry memories, ring pointer,
// pipelined slot search and result register. Depends on rsht_pkg, rsht_if.
module rsht_datapath
    import rsht_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rsht_cmd_t     cmd,
    output rsht_status_t  status,
    rsht_req_if.sink      request,
    rsht_rsp_if.source    result
);

    logic [SLOT_W-1:0] slot_mem [CAPACITY];
    logic [HASH_W-1:0] hash_mem [CAPACITY];

    logic [SLOT_W-1:0]  slot_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [ROW_W-1:0]   newest_reg;
    logic [ROW_W-1:0]   newest_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ROW_W-1:0]   scan_row_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic [ROW_W-1:0]   rd_row_reg;
    logic [ROW_W-1:0]   rd_idx_reg;
    logic               rd_valid_reg;
    logic               hit_reg;
    logic [ROW_W-1:0]   hit_row_reg;
    logic [ROW_W-1:0]   hit_idx_reg;
    logic               out_valid_reg;
    logic               out_matched_reg;
    logic [POS_W-1:0]   out_position_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_evicted_reg;

    logic             issue;
    logic             match;
    logic             last_entry;
    logic             full;
    logic [ROW_W-1:0] wr_row;

    assign issue      = cmd.scan && (scan_idx_reg < count_reg);
    assign match      = (rd_slot_reg == slot_reg);
    assign last_entry = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign full       = (count_reg == FULL_CNT);
    assign newest_next = (newest_reg == '0) ? LAST_ROW : newest_reg - ROW_W'(1);
    assign count_next  = full ? count_reg : count_reg + CNT_W'(1);
    assign wr_row      = hit_reg ? hit_row_reg : newest_next;

    assign status.req_valid  = request.valid;
    assign status.count_zero = (count_reg == '0);
    assign status.found      = rd_valid_reg && match;
    assign status.exhausted  = rd_valid_reg && !match && last_entry;
    assign status.out_free   = !out_valid_reg || result.ready;

    assign request.ready      = cmd.ready;
    assign result.valid       = out_valid_reg;
    assign result.matched     = out_matched_reg;
    assign result.position    = out_position_reg;
    assign result.entry_count = out_count_reg;
    assign result.evicted     = out_evicted_reg;

    // entry memories: one write port each; the slot memory also has one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            slot_mem[wr_row] <= slot_reg;
        end
        if (cmd.commit)
        begin
            hash_mem[wr_row] <= hash_reg;
        end
        rd_slot_reg <= slot_mem[scan_row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg    <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_valid_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= issue;
                if (cmd.scan && status.found)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit && !hit_reg)
            begin
                newest_reg <= newest_next;
                count_reg  <= count_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_reg     <= request.slot;
            hash_reg     <= {request.hash_word3, request.hash_word2,
                             request.hash_word1, request.hash_word0};
            scan_row_reg <= newest_reg;
            scan_idx_reg <= '0;
        end
        else if (issue)
        begin
            scan_row_reg <= (scan_row_reg == LAST_ROW) ? '0 : scan_row_reg + ROW_W'(1);
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        rd_row_reg <= scan_row_reg;
        rd_idx_reg <= scan_idx_reg[ROW_W-1:0];
        if (cmd.scan && status.found)
        begin
            hit_row_reg <= rd_row_reg;
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            out_matched_reg  <= hit_reg;
            out_position_reg <= hit_reg ? POS_W'(hit_idx_reg) : '0;
            out_count_reg    <= hit_reg ? COUNT_W'(count_reg) : COUNT_W'(count_next);
            out_evicted_reg  <= !hit_reg && full;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !hit_reg && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

    a_hit_keeps_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && hit_reg |=> $stable(newest_reg) && $stable(count_reg))
        else $error("hash overwrite moved the ring");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result raised without a commit");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_matched_reg |-> !out_evicted_reg)
        else $error("eviction reported on a hit");

endmodule

### hdl/recent_slot_hash_table_update.sv
// Recent slot hash table update, top level. Keeps a newest-first ring of up
// to CAPACITY (slot, 256-bit hash) entries. One transaction is handled at a
// time: the request is accepted, then the slot memory is read once per entry
// searched from the newest, through its single registered read port, until a
// hit or the last entry (no search on an empty table), then the table is
// written and the result presented once the result register is free. The
// result register lets the next request be accepted while the previous result
// still waits. Reset empties the table at once, with no clearing pass.
// Depends on rsht_pkg, rsht_if, rsht_ctrl and rsht_datapath.
module recent_slot_hash_table_update
    import rsht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsht_req_if.sink   request,
    rsht_rsp_if.source result
);

    rsht_cmd_t    cmd;
    rsht_status_t status;

    rsht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rsht_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .request (request),
        .result  (result)
    );

endmodule
